// ===== hdl/lrr_pkg.sv =====
// Package for the LIN response receiver: sizes, register indexes,
// item codes and result status codes.
// No dependencies.
`default_nettype none

package lrr_pkg;

  localparam int unsigned MAX_DATA_BYTES = 8;
  localparam int unsigned TIMER_BITS     = 24;

  // Field widths
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned ID_W      = 8;
  localparam int unsigned TIMEOUT_W = 24;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 24;
  localparam int unsigned OUT_DAT_W = 40;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DATA_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROTECTED_ID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIMEOUT = 2'd2;

  // Register reset values
  localparam logic [LEN_W-1:0]     DATA_LENGTH_RST   = 4'd8;
  localparam logic [ID_W-1:0]      PROTECTED_ID_RST  = 8'd0;
  localparam logic [TIMEOUT_W-1:0] FRAME_TIMEOUT_RST = 24'd10000;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_IDLE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_PROCESSING = 2'd0,
    ST_VALID      = 2'd1,
    ST_BAD_CHKSUM = 2'd2,
    ST_TIMEOUT    = 2'd3
  } status_e;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_count;
    logic [BYTE_W-1:0] computed_checksum;
    logic [BYTE_W-1:0] received_checksum;
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  data_index;
    logic              data_strobe;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/lin_response_receiver_core.sv =====
// LIN response receiver core: frame phase tracking, enhanced checksum
// check, frame timeout and frame counter behind stream ports.
// Depends on lrr_pkg.
// The result of each accepted request is registered in the output register.
// Throughput: one request per cycle; the output register stalls the input only while a
// result waits and the downstream side holds tready low.
// Reset: rst_ni is asynchronous, active low; registers return to their defaults,
// phase to sync, timer, checksum sum and frame counter to zero, no result pending.
`default_nettype none

module lin_response_receiver_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,

  // Configuration write channel
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [lrr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [lrr_pkg::CFG_DAT_W-1:0]    cfg_data_i,

  // Input stream
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  wire logic [7:0]                       s_axis_tdata_i,  // [7:0] rx_byte
  input  wire logic [1:0]                       s_axis_tuser_i,  // [1:0] mode

  // Result stream
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // [0] data_strobe, [3:1] data_index, [11:4] data_byte, [19:12] received_checksum,
  // [27:20] computed_checksum, [35:28] frame_count, [39:36] zero
  output logic [lrr_pkg::OUT_DAT_W-1:0]         m_axis_tdata_o,
  output logic [1:0]                            m_axis_tuser_o   // [1:0] status
);

  typedef enum logic [1:0] {
    PH_SYNC  = 2'd0,
    PH_ID    = 2'd1,
    PH_DATA  = 2'd2,
    PH_CHKSM = 2'd3
  } phase_e;

  localparam int unsigned CMP_W = 33;  // covers any timer width up to 32
  localparam int unsigned POS_W = lrr_pkg::IDX_W + 1;
  localparam logic [lrr_pkg::TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam logic [lrr_pkg::LEN_W-1:0] MAX_LEN = lrr_pkg::LEN_W'(lrr_pkg::MAX_DATA_BYTES);

  // Configuration registers
  logic [lrr_pkg::LEN_W-1:0]     data_length_q;
  logic [lrr_pkg::ID_W-1:0]      protected_id_q;
  logic [lrr_pkg::TIMEOUT_W-1:0] frame_timeout_q;

  // Frame state
  phase_e                        phase_q, phase_d;
  logic [lrr_pkg::IDX_W-1:0]     pos_q, pos_d;
  logic [lrr_pkg::BYTE_W-1:0]    sum_q, sum_d;
  logic [lrr_pkg::TIMER_BITS-1:0] ticks_q, ticks_d;
  logic [lrr_pkg::BYTE_W-1:0]    frames_q, frames_d;

  // Output register
  logic                          out_valid_q;
  lrr_pkg::status_e              status_q, status_d;
  lrr_pkg::result_t              res_q, res_d;

  logic                          in_acc;
  lrr_pkg::mode_e                mode;
  logic [lrr_pkg::BYTE_W-1:0]    rx;
  logic [lrr_pkg::LEN_W-1:0]     eff_len;
  logic [POS_W-1:0]              pos_next;
  logic [lrr_pkg::BYTE_W:0]      raw_sum;
  logic                          timed_out;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign mode            = lrr_pkg::mode_e'(s_axis_tuser_i);
  assign rx              = s_axis_tdata_i;

  // Length clamp: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (data_length_q == '0) begin
      eff_len = lrr_pkg::LEN_W'(1);
    end else if (data_length_q > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = data_length_q;
    end
  end

  assign pos_next = {1'b0, pos_q} + POS_W'(1);
  // End-around carry add
  assign raw_sum  = {1'b0, sum_q} + {1'b0, rx};

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    ticks_d  = ticks_q;
    frames_d = frames_q;
    status_d = lrr_pkg::ST_PROCESSING;
    res_d    = '0;
    timed_out = 1'b0;

    if (mode == lrr_pkg::MODE_START) begin
      ticks_d = '0;
      phase_d = PH_SYNC;
      pos_d   = '0;
      sum_d   = '0;
    end else begin
      if (mode == lrr_pkg::MODE_TICK && ticks_q != TIMER_MAX) begin
        ticks_d = ticks_q + lrr_pkg::TIMER_BITS'(1);
      end
      timed_out = CMP_W'(ticks_d) > CMP_W'(frame_timeout_q);
      if (timed_out) begin
        phase_d  = PH_SYNC;
        status_d = lrr_pkg::ST_TIMEOUT;
      end else if (mode == lrr_pkg::MODE_BYTE) begin
        unique case (phase_q)
          PH_SYNC: begin
            phase_d = PH_ID;
          end
          PH_ID: begin
            phase_d = PH_DATA;
            pos_d   = '0;
            sum_d   = protected_id_q;
          end
          PH_DATA: begin
            sum_d             = raw_sum[lrr_pkg::BYTE_W-1:0]
                              + lrr_pkg::BYTE_W'(raw_sum[lrr_pkg::BYTE_W]);
            res_d.data_strobe = 1'b1;
            res_d.data_index  = pos_q;
            res_d.data_byte   = rx;
            if (pos_next >= POS_W'(eff_len)) begin
              phase_d = PH_CHKSM;
            end else begin
              pos_d = pos_next[lrr_pkg::IDX_W-1:0];
            end
          end
          PH_CHKSM: begin
            res_d.received_checksum = rx;
            res_d.computed_checksum = ~sum_q;
            frames_d = frames_q + lrr_pkg::BYTE_W'(1);
            phase_d  = PH_SYNC;
            status_d = (rx == ~sum_q) ? lrr_pkg::ST_VALID : lrr_pkg::ST_BAD_CHKSUM;
          end
          default: begin
            phase_d = PH_SYNC;
          end
        endcase
      end
    end
    res_d.frame_count = frames_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_length_q   <= lrr_pkg::DATA_LENGTH_RST;
      protected_id_q  <= lrr_pkg::PROTECTED_ID_RST;
      frame_timeout_q <= lrr_pkg::FRAME_TIMEOUT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        lrr_pkg::REG_DATA_LENGTH:   data_length_q   <= cfg_data_i[lrr_pkg::LEN_W-1:0];
        lrr_pkg::REG_PROTECTED_ID:  protected_id_q  <= cfg_data_i[lrr_pkg::ID_W-1:0];
        lrr_pkg::REG_FRAME_TIMEOUT: frame_timeout_q <= cfg_data_i[lrr_pkg::TIMEOUT_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Frame state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC;
      pos_q       <= '0;
      sum_q       <= '0;
      ticks_q     <= '0;
      frames_q    <= '0;
      out_valid_q <= 1'b0;
      status_q    <= lrr_pkg::ST_PROCESSING;
    end else begin
      if (in_acc) begin
        phase_q     <= phase_d;
        pos_q       <= pos_d;
        sum_q       <= sum_d;
        ticks_q     <= ticks_d;
        frames_q    <= frames_d;
        status_q    <= status_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = lrr_pkg::OUT_DAT_W'(res_q);

`ifndef ASSERT_OFF
  // A result held against back-pressure stays unchanged until taken
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i
    |=> out_valid_q && $stable(res_q) && $stable(status_q))
    else $error("held result changed");

  // Data strobe only on processing results
  a_strobe_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.data_strobe |-> status_q == lrr_pkg::ST_PROCESSING)
    else $error("data strobe with final status");

  // Checksum fields only on frame completion results
  a_chk_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == lrr_pkg::ST_PROCESSING || status_q == lrr_pkg::ST_TIMEOUT)
    |-> (res_q.received_checksum == '0 && res_q.computed_checksum == '0))
    else $error("checksum fields set outside frame end");

  // Frame counter advances on every completed frame
  a_frame_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (status_d == lrr_pkg::ST_VALID || status_d == lrr_pkg::ST_BAD_CHKSUM)
    |=> frames_q == $past(frames_q) + lrr_pkg::BYTE_W'(1))
    else $error("frame counter did not advance");
`endif

endmodule

`default_nettype wire

// ===== tb/lin_response_receiver_core_test.sv =====
// Self-checking testbench for lin_response_receiver_core: drives frames, ticks and
// noise into the request stream, predicts every response and checks it field by field.
// Depends on lrr_pkg and the lin_response_receiver_core RTL.
`timescale 1ns / 100ps

typedef enum logic [1:0] {
  PH_SYNC,
  PH_ID,
  PH_DATA,
  PH_CHECK
} rx_phase_e;

typedef struct packed {
  lrr_pkg::status_e status;
  lrr_pkg::result_t fields;
} response_t;

// End-around carry add of the enhanced checksum
function automatic logic [7:0] wrap_add(logic [7:0] a, logic [7:0] b);
  logic [8:0] s;
  s = {1'b0, a} + {1'b0, b};
  if (s > 9'd255) s = s - 9'd255;
  return s[7:0];
endfunction

// Keeps a private copy of the receiver state and registers, predicts one
// response per accepted request and compares what comes out.
class response_tracker;
  logic [lrr_pkg::LEN_W-1:0]      len_reg;
  logic [lrr_pkg::ID_W-1:0]       pid_reg;
  logic [lrr_pkg::TIMEOUT_W-1:0]  timeout_reg;
  rx_phase_e                      phase;
  logic [lrr_pkg::IDX_W-1:0]      pos;
  logic [lrr_pkg::BYTE_W-1:0]     sum;
  logic [lrr_pkg::TIMER_BITS-1:0] ticks;
  logic [lrr_pkg::BYTE_W-1:0]     frames;
  response_t                      expected_responses[$];
  int                             errors;

  function new();
    len_reg     = lrr_pkg::DATA_LENGTH_RST;
    pid_reg     = lrr_pkg::PROTECTED_ID_RST;
    timeout_reg = lrr_pkg::FRAME_TIMEOUT_RST;
    phase       = PH_SYNC;
    pos         = '0;
    sum         = '0;
    ticks       = '0;
    frames      = '0;
    errors      = 0;
  endfunction

  function void write_reg(logic [lrr_pkg::CFG_IDX_W-1:0] idx,
                          logic [lrr_pkg::CFG_DAT_W-1:0] val);
    case (idx)
      lrr_pkg::REG_DATA_LENGTH:   len_reg = val[lrr_pkg::LEN_W-1:0];
      lrr_pkg::REG_PROTECTED_ID:  pid_reg = val[lrr_pkg::ID_W-1:0];
      lrr_pkg::REG_FRAME_TIMEOUT: timeout_reg = val[lrr_pkg::TIMEOUT_W-1:0];
      default: ;
    endcase
  endfunction

  // Length 0 acts as 1, anything past the store size is clipped
  function int unsigned data_bytes();
    if (len_reg == 0) return 1;
    if (len_reg > lrr_pkg::MAX_DATA_BYTES) return lrr_pkg::MAX_DATA_BYTES;
    return 32'(len_reg);
  endfunction

  function int pending();
    return expected_responses.size();
  endfunction

  function void predict_response(lrr_pkg::mode_e mode, logic [7:0] rx);
    response_t r;
    r.status = lrr_pkg::ST_PROCESSING;
    r.fields = '0;
    if (mode == lrr_pkg::MODE_START) begin
      ticks = '0;
      phase = PH_SYNC;
      pos   = '0;
      sum   = '0;
    end else begin
      if (mode == lrr_pkg::MODE_TICK && ticks != '1) ticks++;
      // timeout keeps the counter, so it repeats until the next start
      if (ticks > timeout_reg) begin
        phase    = PH_SYNC;
        r.status = lrr_pkg::ST_TIMEOUT;
      end else if (mode == lrr_pkg::MODE_BYTE) begin
        case (phase)
          PH_SYNC: phase = PH_ID;
          PH_ID: begin
            phase = PH_DATA;
            pos   = '0;
            sum   = pid_reg;
          end
          PH_DATA: begin
            sum = wrap_add(sum, rx);
            r.fields.data_strobe = 1'b1;
            r.fields.data_index  = pos;
            r.fields.data_byte   = rx;
            if (int'(pos) + 1 >= data_bytes()) phase = PH_CHECK;
            else pos = pos + 1'b1;
          end
          default: begin
            r.fields.received_checksum = rx;
            r.fields.computed_checksum = ~sum;
            frames = frames + 1'b1;
            phase  = PH_SYNC;
            r.status = (rx == ~sum) ? lrr_pkg::ST_VALID : lrr_pkg::ST_BAD_CHKSUM;
          end
        endcase
      end
    end
    r.fields.frame_count = frames;
    expected_responses.push_back(r);
  endfunction

  function void report(string what, longint got, longint want);
    if (errors < 200)
      $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
    errors++;
  endfunction

  function void check_response(logic [lrr_pkg::OUT_DAT_W-1:0] tdata, logic [1:0] tuser);
    response_t        want;
    lrr_pkg::result_t got;
    if (expected_responses.size() == 0) begin
      report("unexpected response", tdata, 0);
      return;
    end
    want = expected_responses.pop_front();
    got  = tdata[$bits(lrr_pkg::result_t)-1:0];
    if (tuser != want.status) report("status", tuser, want.status);
    if (got.data_strobe != want.fields.data_strobe)
      report("data_strobe", got.data_strobe, want.fields.data_strobe);
    if (got.data_index != want.fields.data_index)
      report("data_index", got.data_index, want.fields.data_index);
    if (got.data_byte != want.fields.data_byte)
      report("data_byte", got.data_byte, want.fields.data_byte);
    if (got.received_checksum != want.fields.received_checksum)
      report("received_checksum", got.received_checksum, want.fields.received_checksum);
    if (got.computed_checksum != want.fields.computed_checksum)
      report("computed_checksum", got.computed_checksum, want.fields.computed_checksum);
    if (got.frame_count != want.fields.frame_count)
      report("frame_count", got.frame_count, want.fields.frame_count);
    if (tdata[lrr_pkg::OUT_DAT_W-1:$bits(lrr_pkg::result_t)] != '0)
      report("tdata padding", tdata[lrr_pkg::OUT_DAT_W-1:$bits(lrr_pkg::result_t)], 0);
  endfunction
endclass

module lin_response_receiver_core_test;

  localparam int STALL_LIMIT = 2000;  // cycles without any handshake

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                          cfg_valid = 1'b0;
  logic [lrr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lrr_pkg::CFG_DAT_W-1:0] cfg_data  = '0;
  logic                          cfg_ready;

  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata  = '0;
  logic [1:0] s_tuser  = '0;
  logic       s_tready;

  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [lrr_pkg::OUT_DAT_W-1:0] m_tdata;
  logic [1:0]                    m_tuser;

  response_tracker sb = new();
  int  items_sent = 0;
  bit  pace_gaps  = 1'b0;   // random idling on both sides when set
  int  hold_cnt   = 0;

  lin_response_receiver_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Downstream side: random back-pressure bursts
  always @(posedge clk_i) begin
    if (!pace_gaps) begin
      m_tready <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      hold_cnt = $urandom_range(0, 10);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Response monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_response(m_tdata, m_tuser);
  end

  // Watchdog: ends the run if traffic stops
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // One request; valid stays high after acceptance so back-to-back requests
  // keep it asserted between them. An optional idle burst goes first.
  task send_req(lrr_pkg::mode_e mode, logic [7:0] rx);
    if (pace_gaps && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= rx;
    s_tuser  <= mode;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.predict_response(mode, rx);
    items_sent++;
  endtask

  // Occasional tick or unused-mode request inside a frame
  task maybe_filler();
    if ($urandom_range(0, 4) == 0)
      send_req($urandom_range(0, 1) ? lrr_pkg::MODE_TICK : lrr_pkg::MODE_IDLE,
               8'($urandom_range(0, 255)));
  endtask

  // Drop valid and wait for every outstanding response, plus the output latency
  task drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task write_reg(logic [lrr_pkg::CFG_IDX_W-1:0] idx, logic [lrr_pkg::CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // Only called with the block idle
  task configure(logic [lrr_pkg::LEN_W-1:0] len, logic [lrr_pkg::ID_W-1:0] pid,
                 logic [lrr_pkg::TIMEOUT_W-1:0] tmo);
    write_reg(lrr_pkg::REG_DATA_LENGTH, lrr_pkg::CFG_DAT_W'(len));
    write_reg(lrr_pkg::REG_PROTECTED_ID, lrr_pkg::CFG_DAT_W'(pid));
    write_reg(lrr_pkg::REG_FRAME_TIMEOUT, tmo);
    cfg_valid <= 1'b0;
  endtask

  // A frame with random content. extra shifts the data byte count by -1..1
  // to make broken frames; corrupt flips bits of the checksum byte.
  task send_frame(bit with_start, int extra, bit corrupt);
    int         n;
    logic [7:0] chk;
    logic [7:0] b;
    n   = int'(sb.data_bytes()) + extra;
    chk = sb.pid_reg;
    if (with_start) send_req(lrr_pkg::MODE_START, 8'($urandom_range(0, 255)));
    maybe_filler();
    send_req(lrr_pkg::MODE_BYTE,
             ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h55);
    send_req(lrr_pkg::MODE_BYTE, 8'($urandom_range(0, 255)));
    for (int i = 0; i < n; i++) begin
      b   = 8'($urandom_range(0, 255));
      chk = wrap_add(chk, b);
      send_req(lrr_pkg::MODE_BYTE, b);
      maybe_filler();
    end
    b = ~chk;
    if (corrupt) b = b ^ 8'($urandom_range(1, 255));
    send_req(lrr_pkg::MODE_BYTE, b);
  endtask

  initial begin
    logic [7:0] edge_bytes [8];
    logic [7:0] dsum;
    int         target;
    bit         pressure_done;
    int         pick;

    edge_bytes    = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hAA, 8'h55, 8'hFE};
    pressure_done = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, full-length frame with extreme data bytes
    dsum = lrr_pkg::PROTECTED_ID_RST;
    send_req(lrr_pkg::MODE_START, 8'hFF);
    send_req(lrr_pkg::MODE_BYTE, 8'h55);
    send_req(lrr_pkg::MODE_BYTE, 8'h3C);
    for (int i = 0; i < 8; i++) begin
      dsum = wrap_add(dsum, edge_bytes[i]);
      send_req(lrr_pkg::MODE_BYTE, edge_bytes[i]);
    end
    send_req(lrr_pkg::MODE_BYTE, ~dsum);
    send_req(lrr_pkg::MODE_IDLE, 8'h00);
    drain();

    // Zero length acts as one byte, zero timeout trips on the first tick
    configure(4'd0, 8'hFF, 24'd0);
    send_req(lrr_pkg::MODE_START, 8'h00);
    send_req(lrr_pkg::MODE_BYTE, 8'h55);
    send_req(lrr_pkg::MODE_BYTE, 8'hC1);
    send_req(lrr_pkg::MODE_BYTE, 8'hFF);
    send_req(lrr_pkg::MODE_BYTE, 8'h01);   // wrong checksum
    send_req(lrr_pkg::MODE_TICK, 8'h00);   // timeout
    send_req(lrr_pkg::MODE_BYTE, 8'h12);   // still timed out
    send_req(lrr_pkg::MODE_IDLE, 8'hFF);   // still timed out
    send_req(lrr_pkg::MODE_START, 8'h00);
    send_req(lrr_pkg::MODE_IDLE, 8'h00);   // processing again
    drain();

    // Random phases, each with its own register settings
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: configure(4'd1, 8'h00, 24'hFFFFFF);
        1: configure(4'd8, 8'hFF, 24'd0);
        2: configure(4'd0, 8'($urandom_range(0, 255)), 24'($urandom_range(0, 8)));
        3: configure(4'd15, 8'($urandom_range(0, 255)), 24'($urandom_range(3, 20)));
        4: configure(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                     24'($urandom_range(0, 30)));
        default: configure(4'($urandom_range(1, 8)), 8'($urandom_range(0, 255)),
                           24'($urandom_range(16, 60)));
      endcase
      target = items_sent + 205;
      while (items_sent < target) begin
        // last phase runs without idling
        pace_gaps = (ph != 5) && ($urandom_range(0, 4) != 0);
        if (ph == 4 && !pressure_done && items_sent > target - 100) begin
          drain();
          pressure_done = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 70)
          send_frame(1'b1, 0, $urandom_range(0, 9) == 0);
        else if (pick < 85)
          send_frame(1'($urandom_range(0, 1)), int'($urandom_range(0, 2)) - 1,
                     1'($urandom_range(0, 1)));
        else
          repeat ($urandom_range(1, 6))
            send_req(lrr_pkg::mode_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end

    drain();
    repeat (5) @(posedge clk_i);
    if (sb.pending() != 0) sb.report("responses never seen", sb.pending(), 0);
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
